### src/lzwd_pkg.sv
// Package for the LZW code decoder: widths, dictionary entry type, status codes.
// No dependencies.
`timescale 1ns / 1ps
package lzwd_pkg;
  localparam int CODE_W    = 12;
  localparam int DICT_N    = 4096;
  localparam int DICT_AW   = 12;
  localparam int NF_W      = 13;
  localparam int LIT_CODES = 256;
  localparam int MAX_LEN   = 512;
  localparam int STK_AW    = 9;
  localparam int LEN_W     = 10;
  localparam int LENX_W    = 11;
  localparam int BPR       = 8;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_TOOLONG = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [7:0]        suffix;
    logic [7:0]        first;
    logic [LEN_W-1:0]  len;
  } dict_entry_t;
endpackage

### src/lzwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/lzw_code_decoder_top.sv
// LZW code decoder top level: sequencer, dictionary RAM and string stack RAM.
// Depends on lzwd_pkg and lzwd_ram.
`timescale 1ns / 1ps
// One 12-bit code is taken at a time; in_ready is low until its last word has gone.
// A code passes through a dictionary lookup, then a walk of its prefix chain (string
// length L, up to 512) into the string stack, then a read-back of the stack into
// output words of up to eight bytes. Faulty codes give one error word and leave the
// dictionary untouched. No clearing pass after reset.
module lzw_code_decoder_top
  import lzwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_last_of_code,
  output logic [1:0]  out_status
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDP   = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_GATH  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_ERR   = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [NF_W-1:0]   nf_r, nf_nxt;
  logic [CODE_W-1:0] prev_r, prev_nxt;
  logic              hp_r, hp_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [CODE_W-1:0] c_r, c_nxt;
  dict_entry_t       cent_r, cent_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [3:0]        k_r, k_nxt;
  logic [63:0]       data_r, data_nxt;
  logic [7:0]        first_r, first_nxt;
  logic [7:0]        pfirst_r, pfirst_nxt;
  logic [LEN_W-1:0]  newlen_r, newlen_nxt;
  logic              add_r, add_nxt;
  logic [1:0]        err_r, err_nxt;

  logic              d_we;
  logic [DICT_AW-1:0] d_waddr, d_raddr;
  dict_entry_t       d_wdata, d_rdata;
  logic              s_we;
  logic [STK_AW-1:0] s_waddr, s_raddr;
  logic [7:0]        s_wdata, s_rdata;

  logic              code_lit, prev_lit, kwk, dict_room, out_fire, last_w;
  logic [LENX_W-1:0] code_len, prev_len1, len_x;
  logic [7:0]        code_first, prev_first;

  lzwd_ram #(.WIDTH($bits(dict_entry_t)), .DEPTH(DICT_N)) u_dict (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  lzwd_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign code_lit   = (code_r < CODE_W'(LIT_CODES));
  assign prev_lit   = (prev_r < CODE_W'(LIT_CODES));
  assign code_len   = code_lit ? LENX_W'(1) : LENX_W'(cent_r.len);
  assign code_first = code_lit ? code_r[7:0] : cent_r.first;
  assign prev_len1  = (prev_lit ? LENX_W'(1) : LENX_W'(d_rdata.len)) + LENX_W'(1);
  assign prev_first = prev_lit ? prev_r[7:0] : d_rdata.first;
  assign dict_room  = (nf_r < NF_W'(DICT_N));
  assign kwk        = !({1'b0, code_r} < nf_r) && hp_r && ({1'b0, code_r} == nf_r) && dict_room;
  assign len_x      = kwk ? prev_len1 : code_len;
  assign last_w     = (idx_r == len_r);
  assign out_fire   = out_valid && out_ready;

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = (state_r == S_EMIT) || (state_r == S_ERR);
  assign out_data_bytes   = (state_r == S_ERR) ? 64'd0 : data_r;
  assign out_byte_count   = (state_r == S_ERR) ? 4'd0 : k_r;
  assign out_last_of_code = (state_r == S_ERR) ? 1'b1 : last_w;
  assign out_status       = (state_r == S_ERR) ? err_r : ST_OK;

  always_comb begin
    state_nxt  = state_r;
    nf_nxt     = nf_r;
    prev_nxt   = prev_r;
    hp_nxt     = hp_r;
    code_nxt   = code_r;
    c_nxt      = c_r;
    cent_nxt   = cent_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    idx_nxt    = idx_r;
    k_nxt      = k_r;
    data_nxt   = data_r;
    first_nxt  = first_r;
    pfirst_nxt = pfirst_r;
    newlen_nxt = newlen_r;
    add_nxt    = add_r;
    err_nxt    = err_r;
    d_we       = 1'b0;
    d_waddr    = nf_r[DICT_AW-1:0];
    d_wdata    = '{prefix: prev_r, suffix: first_r, first: pfirst_r, len: newlen_r};
    d_raddr    = c_r;
    s_we       = 1'b0;
    s_waddr    = pos_r[STK_AW-1:0] - STK_AW'(1);
    s_wdata    = c_r[7:0];
    s_raddr    = idx_r[STK_AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        d_raddr = in_code;
        if (in_valid) begin
          code_nxt  = in_code;
          state_nxt = S_RDP;
        end
      end
      S_RDP: begin
        cent_nxt  = d_rdata;
        d_raddr   = prev_r;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        first_nxt  = kwk ? prev_first : code_first;
        pfirst_nxt = prev_first;
        newlen_nxt = prev_len1[LEN_W-1:0];
        add_nxt    = hp_r && dict_room;
        len_nxt    = len_x[LEN_W-1:0];
        if (!({1'b0, code_r} < nf_r) && !kwk) begin
          err_nxt   = ST_BAD;
          state_nxt = S_ERR;
        end else if ((hp_r && dict_room && prev_len1 > LENX_W'(MAX_LEN)) ||
                     len_x > LENX_W'(MAX_LEN) || len_x == '0) begin
          err_nxt   = ST_TOOLONG;
          state_nxt = S_ERR;
        end else if (kwk) begin
          s_we      = 1'b1;
          s_waddr   = len_x[STK_AW-1:0] - STK_AW'(1);
          s_wdata   = prev_first;
          c_nxt     = prev_r;
          d_raddr   = prev_r;
          pos_nxt   = len_x[LEN_W-1:0] - LEN_W'(1);
          state_nxt = S_WALK;
        end else begin
          c_nxt     = code_r;
          d_raddr   = code_r;
          pos_nxt   = len_x[LEN_W-1:0];
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        s_we = 1'b1;
        if (c_r < CODE_W'(LIT_CODES)) begin
          s_wdata   = c_r[7:0];
          idx_nxt   = '0;
          k_nxt     = '0;
          data_nxt  = '0;
          state_nxt = S_FETCH;
        end else begin
          s_wdata = d_rdata.suffix;
          d_raddr = d_rdata.prefix;
          c_nxt   = d_rdata.prefix;
          pos_nxt = pos_r - LEN_W'(1);
        end
      end
      S_FETCH: begin
        state_nxt = S_GATH;
      end
      S_GATH: begin
        s_raddr = idx_r[STK_AW-1:0] + STK_AW'(1);
        data_nxt[63 - 8*k_r[2:0] -: 8] = s_rdata;
        idx_nxt = idx_r + LEN_W'(1);
        k_nxt   = k_r + 4'd1;
        if (k_r == 4'(BPR - 1) || idx_r + LEN_W'(1) == len_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_fire) begin
          if (last_w) begin
            if (add_r) begin
              d_we   = 1'b1;
              nf_nxt = nf_r + NF_W'(1);
            end
            prev_nxt  = code_r;
            hp_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = '0;
            data_nxt  = '0;
            state_nxt = S_FETCH;
          end
        end
      end
      S_ERR: begin
        if (out_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nf_r    <= NF_W'(LIT_CODES);
      prev_r  <= '0;
      hp_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nf_r    <= nf_nxt;
      prev_r  <= prev_nxt;
      hp_r    <= hp_nxt;
    end
    code_r   <= code_nxt;
    c_r      <= c_nxt;
    cent_r   <= cent_nxt;
    len_r    <= len_nxt;
    pos_r    <= pos_nxt;
    idx_r    <= idx_nxt;
    k_r      <= k_nxt;
    data_r   <= data_nxt;
    first_r  <= first_nxt;
    pfirst_r <= pfirst_nxt;
    newlen_r <= newlen_nxt;
    add_r    <= add_nxt;
    err_r    <= err_nxt;
  end
endmodule
